/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked assertion, disabled while reset is held low
`define PTS_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion, checked during reset too
`define PTS_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PTS_ASSERT_RST(lbl, clk, rstn, prop, msg)
`define PTS_ASSERT(lbl, clk, prop, msg)

`endif

`endif

/* hw/rtl/pts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants of the PWM throttle slew limiter.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int unsigned MOTORS_DEF = 8;

    localparam int unsigned PULSE_W    = 16;
    localparam int unsigned THR_W      = 17;
    localparam int unsigned IDX_FIELD_W = 3;

    localparam logic [THR_W-1:0]   FULL_SCALE     = 17'h10000;
    localparam logic [PULSE_W-1:0] PULSE_MIN_RST  = 16'd1000;
    localparam logic [PULSE_W-1:0] PULSE_MAX_RST  = 16'd2000;
    localparam logic [THR_W-1:0]   STEP_LIMIT_RST = 17'h10000;

    // Quotient bits produced by the divider, one per cycle
    localparam int unsigned DIV_STEPS = 16;
    localparam int unsigned DIV_CNT_W = 5;

    localparam int unsigned APB_AW = 4;
    localparam int unsigned APB_DW = 32;

    // Register word index (paddr[3:2])
    typedef enum logic [1:0] {
        CFG_PULSE_MIN  = 2'd0,
        CFG_PULSE_MAX  = 2'd1,
        CFG_STEP_LIMIT = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SLEW
    } state_t;

    typedef struct packed {
        logic [IDX_FIELD_W-1:0] motor_index;
        logic [PULSE_W-1:0]     pulse_width;
    } in_t;

    typedef struct packed {
        logic [IDX_FIELD_W-1:0] motor_out;
        logic [THR_W-1:0]       throttle;
    } out_t;

endpackage

/* hw/rtl/pwm_throttle_slew_limiter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_throttle_slew_limiter
// PWM pulse width to Q1.16 throttle with a per-motor slew-rate clamp.
// ----------------------------------------------------------------------------
// One request is taken at a time. A width at or below pulse_min or at or
// above pulse_max does not start the divider; a width between the limits
// goes through the 16-step serial divider before the slew clamp. The result
// sits in an output register, so the next request is taken while it waits
// for m_ready. The last throttle of each motor lives in a small synchronous
// RAM (one read and one write port, registered read data) with a valid bit
// per entry that reset clears, so no clearing pass is needed. Motors at or
// beyond MOTORS return throttle 0 and leave the RAM untouched. Registers:
// pulse_min at 0x0, pulse_max at 0x4, step_limit at 0x8.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pwm_throttle_slew_limiter #(
    parameter int unsigned MOTORS = pts_pkg::MOTORS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  pts_pkg::in_t                 s_data,

    output logic                         m_valid,
    input  logic                         m_ready,
    output pts_pkg::out_t                m_data,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pts_pkg::APB_AW-1:0]   paddr,
    input  logic [pts_pkg::APB_DW-1:0]   pwdata,
    output logic [pts_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    localparam int unsigned IDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [pts_pkg::PULSE_W-1:0] pulse_min_reg;
    logic [pts_pkg::PULSE_W-1:0] pulse_max_reg;
    logic [pts_pkg::THR_W-1:0]   step_limit_reg;
    logic                        cfg_wr;
    pts_pkg::cfg_idx_t           cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = pts_pkg::cfg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_min_reg  <= pts_pkg::PULSE_MIN_RST;
            pulse_max_reg  <= pts_pkg::PULSE_MAX_RST;
            step_limit_reg <= pts_pkg::STEP_LIMIT_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                pts_pkg::CFG_PULSE_MIN:  pulse_min_reg  <= pwdata[pts_pkg::PULSE_W-1:0];
                pts_pkg::CFG_PULSE_MAX:  pulse_max_reg  <= pwdata[pts_pkg::PULSE_W-1:0];
                pts_pkg::CFG_STEP_LIMIT: step_limit_reg <= pwdata[pts_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            pts_pkg::CFG_PULSE_MIN:  prdata = pts_pkg::APB_DW'(pulse_min_reg);
            pts_pkg::CFG_PULSE_MAX:  prdata = pts_pkg::APB_DW'(pulse_max_reg);
            pts_pkg::CFG_STEP_LIMIT: prdata = pts_pkg::APB_DW'(step_limit_reg);
            default:                 prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Request capture and classification
    // ------------------------------------------------------------------
    pts_pkg::state_t state_reg;
    pts_pkg::state_t state_next;

    pts_pkg::in_t    item_reg;
    logic            in_range_reg;
    logic            tgt_zero_reg;
    logic            tgt_full_reg;

    logic            s_accept;
    logic [31:0]     s_idx_wide;
    logic            s_in_range;
    logic            s_below;
    logic            s_above;
    logic            div_start;
    logic            div_busy;
    logic [pts_pkg::DIV_STEPS-1:0] div_quot;

    assign s_accept   = s_valid && s_ready;
    assign s_idx_wide = 32'(s_data.motor_index);
    assign s_in_range = (s_idx_wide < 32'(MOTORS));
    // Test against pulse_min first so out-of-order limits resolve the same way
    assign s_below    = (s_data.pulse_width <= pulse_min_reg);
    assign s_above    = !s_below && (s_data.pulse_width >= pulse_max_reg);

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg     <= s_data;
            in_range_reg <= s_in_range;
            tgt_zero_reg <= s_below;
            tgt_full_reg <= s_above;
        end
    end

    pts_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (s_data.pulse_width - pulse_min_reg),
        .divisor  (pulse_max_reg - pulse_min_reg),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    // ------------------------------------------------------------------
    // Throttle memory
    // ------------------------------------------------------------------
    logic [pts_pkg::THR_W-1:0] thr_mem [MOTORS];
    logic [pts_pkg::THR_W-1:0] mem_rdata_reg;
    logic [MOTORS-1:0]         vld_reg;
    logic                      rd_vld_reg;
    logic                      mem_re;
    logic                      mem_we;
    logic [IDX_W-1:0]          mem_raddr;
    logic [IDX_W-1:0]          mem_waddr;
    logic [31:0]               item_idx_wide;
    logic [pts_pkg::THR_W-1:0] slew_res;

    assign item_idx_wide = 32'(item_reg.motor_index);
    assign mem_raddr     = s_idx_wide[IDX_W-1:0];
    assign mem_waddr     = item_idx_wide[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            thr_mem[mem_waddr] <= slew_res;
        end
        if (mem_re) begin
            mem_rdata_reg <= thr_mem[mem_raddr];
        end
    end

    // Never-written entries read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (mem_we) begin
                vld_reg[mem_waddr] <= 1'b1;
            end
            if (mem_re) begin
                rd_vld_reg <= vld_reg[mem_raddr];
            end
        end
    end

    // ------------------------------------------------------------------
    // Slew clamp
    // ------------------------------------------------------------------
    logic [pts_pkg::THR_W-1:0] last_thr;
    logic [pts_pkg::THR_W-1:0] target;
    logic [pts_pkg::THR_W-1:0] diff;
    logic [pts_pkg::THR_W-1:0] lim;
    logic                      going_up;

    assign last_thr = rd_vld_reg ? mem_rdata_reg : '0;
    assign target   = tgt_zero_reg ? '0 :
                      tgt_full_reg ? pts_pkg::FULL_SCALE :
                                     pts_pkg::THR_W'(div_quot);
    assign going_up = (target >= last_thr);
    assign diff     = going_up ? (target - last_thr) : (last_thr - target);
    assign lim      = (diff > step_limit_reg) ? step_limit_reg : diff;
    assign slew_res = going_up ? (last_thr + lim) : (last_thr - lim);

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    logic          m_valid_reg;
    pts_pkg::out_t m_data_reg;
    logic          out_free;
    logic          out_load;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pts_pkg::ST_IDLE: begin
                if (s_accept) begin
                    state_next = pts_pkg::ST_DIV;
                end
            end
            pts_pkg::ST_DIV: begin
                if (!div_busy) begin
                    state_next = pts_pkg::ST_SLEW;
                end
            end
            pts_pkg::ST_SLEW: begin
                if (out_free) begin
                    state_next = pts_pkg::ST_IDLE;
                end
            end
            default: state_next = pts_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = (state_reg == pts_pkg::ST_IDLE);
        div_start = s_accept && !s_below && !s_above;
        mem_re    = s_accept && s_in_range;
        out_load  = (state_reg == pts_pkg::ST_SLEW) && out_free;
        mem_we    = out_load && in_range_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pts_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.motor_out <= item_reg.motor_index;
            m_data_reg.throttle  <= in_range_reg ? slew_res : '0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PTS_ASSERT_RST(a_thr_range, aclk, aresetn, m_valid |-> (m_data.throttle <= pts_pkg::FULL_SCALE), "throttle above full scale")
    `PTS_ASSERT_RST(a_one_at_a_time, aclk, aresetn, s_accept |=> !s_ready, "request taken while busy")
    `PTS_ASSERT_RST(a_div_done, aclk, aresetn, (state_reg == pts_pkg::ST_SLEW) |-> !div_busy, "slew with divider busy")
    `PTS_ASSERT_RST(a_oob_zero, aclk, aresetn, (m_valid && (32'(m_data.motor_out) >= 32'(MOTORS))) |-> (m_data.throttle == '0), "unknown motor gave throttle")
    `PTS_ASSERT(a_rst_idle, aclk, !aresetn |=> (!m_valid && s_ready), "not idle after reset")

endmodule

/* hw/rtl/pts_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_div
// Restoring divider for (a * 2^16) / d with a < d, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module pts_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [pts_pkg::PULSE_W-1:0]    dividend,
    input  logic [pts_pkg::PULSE_W-1:0]    divisor,
    output logic                           busy,
    output logic [pts_pkg::DIV_STEPS-1:0]  quotient
);

    logic [pts_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [pts_pkg::DIV_CNT_W-1:0] cnt_next;
    logic [pts_pkg::PULSE_W-1:0]   rem_reg;
    logic [pts_pkg::PULSE_W-1:0]   rem_next;
    logic [pts_pkg::PULSE_W-1:0]   den_reg;
    logic [pts_pkg::DIV_STEPS-1:0] quot_reg;
    logic [pts_pkg::DIV_STEPS-1:0] quot_next;
    logic [pts_pkg::PULSE_W:0]     rem2;
    logic [pts_pkg::PULSE_W:0]     rem2_sub;
    logic                          qbit;

    assign busy     = (cnt_reg != '0);
    assign quotient = quot_reg;

    // Remainder stays below the divisor, so its double fits one extra bit
    assign rem2     = {rem_reg, 1'b0};
    assign rem2_sub = rem2 - {1'b0, den_reg};
    assign qbit     = (rem2 >= {1'b0, den_reg});

    always_comb begin
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (start) begin
            cnt_next  = pts_pkg::DIV_CNT_W'(pts_pkg::DIV_STEPS);
            rem_next  = dividend;
            quot_next = '0;
        end else if (busy) begin
            cnt_next  = cnt_reg - 1'b1;
            rem_next  = qbit ? rem2_sub[pts_pkg::PULSE_W-1:0] : rem2[pts_pkg::PULSE_W-1:0];
            quot_next = {quot_reg[pts_pkg::DIV_STEPS-2:0], qbit};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        if (start) begin
            den_reg <= divisor;
        end
    end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PWM throttle slew limiter.
// ----------------------------------------------------------------------------
// A directed table covers the width extremes, the limit edges, limits out of
// order, a frozen and an unlimited slew step. Randomised phases follow, each
// with its own register setting and idling pattern. Typed rows are
// checked against the table, others against an in-bench per-motor predictor.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 6;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 200;
    localparam int DRAIN_CYCLES   = 25;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DIR_ROWS       = 28;

    typedef struct packed {
        logic                            cfg_write;
        pts_pkg::cfg_idx_t               reg_sel;
        logic [pts_pkg::THR_W-1:0]       value;
        logic [pts_pkg::IDX_FIELD_W-1:0] motor;
        logic [pts_pkg::PULSE_W-1:0]     pulse;
        logic                            typed;
        logic [pts_pkg::THR_W-1:0]       thr;
    } vec_row_t;

    logic                         aclk;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    pts_pkg::in_t                 s_data;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    pts_pkg::out_t                m_data;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [pts_pkg::APB_AW-1:0]   paddr;
    logic [pts_pkg::APB_DW-1:0]   pwdata;
    logic [pts_pkg::APB_DW-1:0]   prdata;
    logic                         pready;

    // Predictor state
    logic [pts_pkg::PULSE_W-1:0]  cfg_min;
    logic [pts_pkg::PULSE_W-1:0]  cfg_max;
    logic [pts_pkg::THR_W-1:0]    cfg_step;
    logic [pts_pkg::THR_W-1:0]    motor_throttle [pts_pkg::MOTORS_DEF];

    pts_pkg::out_t                throttle_due [$];
    pts_pkg::out_t                got_due;
    vec_row_t                     directed_tab [0:DIR_ROWS-1];
    int                           mismatch_count;
    int                           quiet_cycles = 0;
    int                           src_idle_pct;
    int                           sink_stall_pct;

    pwm_throttle_slew_limiter DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    function automatic vec_row_t item_row(int motor, int pulse);
        vec_row_t r;
        r = '0;
        r.motor = pts_pkg::IDX_FIELD_W'(motor);
        r.pulse = pts_pkg::PULSE_W'(pulse);
        return r;
    endfunction

    function automatic vec_row_t typed_row(int motor, int pulse, int thr);
        vec_row_t r;
        r = item_row(motor, pulse);
        r.typed = 1'b1;
        r.thr = pts_pkg::THR_W'(thr);
        return r;
    endfunction

    function automatic vec_row_t cfg_row(pts_pkg::cfg_idx_t sel, int value);
        vec_row_t r;
        r = '0;
        r.cfg_write = 1'b1;
        r.reg_sel = sel;
        r.value = pts_pkg::THR_W'(value);
        return r;
    endfunction

    // Map the width, clamp the change, advance the motor's stored throttle
    function automatic logic [pts_pkg::THR_W-1:0] next_throttle(pts_pkg::in_t req);
        logic [pts_pkg::THR_W-1:0] target;
        logic [pts_pkg::THR_W-1:0] last;
        logic [pts_pkg::THR_W-1:0] diff;
        logic [31:0]               num;
        logic [pts_pkg::THR_W-1:0] res;
        if (req.motor_index >= pts_pkg::MOTORS_DEF) begin
            return '0;
        end
        if (req.pulse_width <= cfg_min) begin
            target = '0;
        end else if (req.pulse_width >= cfg_max) begin
            target = pts_pkg::FULL_SCALE;
        end else begin
            num = 32'(req.pulse_width - cfg_min) << 16;
            target = pts_pkg::THR_W'(num / 32'(cfg_max - cfg_min));
        end
        last = motor_throttle[req.motor_index];
        if (target >= last) begin
            diff = target - last;
            if (diff > cfg_step) diff = cfg_step;
            res = last + diff;
        end else begin
            diff = last - target;
            if (diff > cfg_step) diff = cfg_step;
            res = last - diff;
        end
        motor_throttle[req.motor_index] = res;
        return res;
    endfunction

    task automatic log_mismatch(string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic push_request(pts_pkg::in_t req, logic typed,
                                logic [pts_pkg::THR_W-1:0] thr);
        pts_pkg::out_t due;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        due.motor_out = req.motor_index;
        due.throttle  = next_throttle(req);
        if (typed) due.throttle = thr;
        throttle_due.push_back(due);
        @(negedge aclk);
    endtask

    // Hold off the sender until every expected result has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (throttle_due.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(pts_pkg::cfg_idx_t sel, logic [pts_pkg::THR_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= pts_pkg::APB_DW'(val);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (sel)
            pts_pkg::CFG_PULSE_MIN:  cfg_min  = val[pts_pkg::PULSE_W-1:0];
            pts_pkg::CFG_PULSE_MAX:  cfg_max  = val[pts_pkg::PULSE_W-1:0];
            pts_pkg::CFG_STEP_LIMIT: cfg_step = val;
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (throttle_due.size() == 0) begin
                log_mismatch($sformatf("unexpected result motor %0d throttle %0d",
                                       m_data.motor_out, m_data.throttle));
            end else begin
                got_due = throttle_due.pop_front();
                if (m_data.motor_out !== got_due.motor_out)
                    log_mismatch($sformatf("motor_out %0d, want %0d",
                                           m_data.motor_out, got_due.motor_out));
                if (m_data.throttle !== got_due.throttle)
                    log_mismatch($sformatf("motor %0d throttle %0d, want %0d",
                                           got_due.motor_out, m_data.throttle,
                                           got_due.throttle));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        pts_pkg::in_t                req;
        logic [pts_pkg::PULSE_W-1:0] lo_w;
        logic [pts_pkg::PULSE_W-1:0] hi_w;
        logic [pts_pkg::PULSE_W-1:0] tmp_w;
        logic [pts_pkg::THR_W-1:0]   step_w;
        int                          lo;
        int                          hi;
        int                          margin;
        int                          pick;

        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        mismatch_count = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;

        cfg_min  = pts_pkg::PULSE_MIN_RST;
        cfg_max  = pts_pkg::PULSE_MAX_RST;
        cfg_step = pts_pkg::STEP_LIMIT_RST;
        for (int i = 0; i < pts_pkg::MOTORS_DEF; i++) motor_throttle[i] = '0;

        directed_tab = '{
            typed_row(0, 0, 0),
            typed_row(0, 65535, 65536),
            typed_row(7, 2000, 65536),
            typed_row(7, 1000, 0),
            typed_row(1, 1500, 32768),
            item_row(1, 1001),
            item_row(2, 1999),
            cfg_row(pts_pkg::CFG_STEP_LIMIT, 0),
            typed_row(0, 0, 65536),         // frozen
            item_row(1, 2000),
            cfg_row(pts_pkg::CFG_STEP_LIMIT, 1000),
            typed_row(0, 0, 64536),
            item_row(2, 0),
            cfg_row(pts_pkg::CFG_PULSE_MIN, 3000),   // limits out of order
            typed_row(3, 2500, 0),
            typed_row(3, 3001, 1000),
            cfg_row(pts_pkg::CFG_PULSE_MAX, 3000),   // limits equal
            typed_row(3, 3000, 0),
            typed_row(3, 3001, 1000),
            cfg_row(pts_pkg::CFG_PULSE_MIN, 0),
            cfg_row(pts_pkg::CFG_PULSE_MAX, 65535),
            cfg_row(pts_pkg::CFG_STEP_LIMIT, 65536),
            item_row(4, 65534),
            item_row(4, 1),
            typed_row(5, 0, 0),
            typed_row(5, 65535, 65536),
            item_row(6, 16'h5555),
            item_row(2, 16'hAAAA)
        };

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int row = 0; row < DIR_ROWS; row++) begin
            if (directed_tab[row].cfg_write) begin
                wait_drained();
                write_reg(directed_tab[row].reg_sel, directed_tab[row].value);
            end else begin
                req.motor_index = directed_tab[row].motor;
                req.pulse_width = directed_tab[row].pulse;
                push_request(req, directed_tab[row].typed, directed_tab[row].thr);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            case (phase)
                0: begin
                    lo_w = 16'd1000;  hi_w = 16'd2000;  step_w = pts_pkg::FULL_SCALE;
                end
                1: begin lo_w = 16'd0;     hi_w = 16'd65535; step_w = 17'd1; end
                2: begin lo_w = 16'd65535; hi_w = 16'd0;     step_w = 17'd512; end
                4: begin
                    lo_w = 16'd0;     hi_w = 16'd1;     step_w = pts_pkg::FULL_SCALE;
                end
                6: begin
                    lo_w = 16'd20000;
                    hi_w = 16'd20003;
                    step_w = pts_pkg::THR_W'($urandom_range(0, 65536));
                end
                default: begin
                    lo_w = pts_pkg::PULSE_W'($urandom_range(0, 60000));
                    if ($urandom_range(0, 3) == 0)
                        hi_w = lo_w + pts_pkg::PULSE_W'($urandom_range(1, 5535));
                    else
                        hi_w = lo_w + pts_pkg::PULSE_W'($urandom_range(1, 600));
                    if ($urandom_range(0, 3) == 0)
                        step_w = pts_pkg::FULL_SCALE;
                    else
                        step_w = pts_pkg::THR_W'($urandom_range(0, 4000));
                    if ($urandom_range(0, 7) == 0) begin
                        tmp_w = lo_w;
                        lo_w = hi_w;
                        hi_w = tmp_w;
                    end
                end
            endcase
            write_reg(pts_pkg::CFG_PULSE_MIN, pts_pkg::THR_W'(lo_w));
            write_reg(pts_pkg::CFG_PULSE_MAX, pts_pkg::THR_W'(hi_w));
            write_reg(pts_pkg::CFG_STEP_LIMIT, step_w);

            src_idle_pct   = (phase % 4 == 1) ? 69 : (phase % 4 == 3) ? 8 : 0;
            sink_stall_pct = (phase % 4 == 2) ? 69 : (phase % 4 == 3) ? 8 : 0;

            lo = (cfg_min < cfg_max) ? int'(cfg_min) : int'(cfg_max);
            hi = (cfg_min < cfg_max) ? int'(cfg_max) : int'(cfg_min);
            margin = (hi - lo) / 4 + 4;
            lo = (lo - margin < 0) ? 0 : lo - margin;
            hi = (hi + margin > 65535) ? 65535 : hi + margin;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 1 && n == PHASE_ITEMS / 2) wait_drained();
                req.motor_index = pts_pkg::IDX_FIELD_W'(
                    $urandom_range(0, pts_pkg::MOTORS_DEF - 1));
                pick = $urandom_range(0, 9);
                if (pick < 2) begin
                    req.pulse_width = pts_pkg::PULSE_W'($urandom_range(0, 65535));
                end else if (pick == 2) begin
                    case ($urandom_range(0, 3))
                        0: req.pulse_width = cfg_min;
                        1: req.pulse_width = cfg_max;
                        2: req.pulse_width = cfg_min + 16'd1;
                        default: req.pulse_width = cfg_max - 16'd1;
                    endcase
                end else begin
                    req.pulse_width = pts_pkg::PULSE_W'($urandom_range(lo, hi));
                end
                push_request(req, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (throttle_due.size() != 0)
            log_mismatch($sformatf("%0d results never arrived", throttle_due.size()));
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
